// File: rtl/core/swpm_pkg.sv
// shared constants and types for the sliding window peak midpoint block
// no dependencies; imported by every module in rtl/core
`timescale 1ns / 1ps

package swpm_pkg;

    localparam int WINDOW   = 32;
    localparam int SAMPLE_W = 12;
    localparam int TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
    localparam int ADDR_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W   = $clog2(WINDOW + 1);

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [FILL_W-1:0]   t_fill;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic    load;
        logic    cmp;
        t_sample sample;
    } t_scan_ctl;

endpackage

// File: rtl/core/swpm_ram.sv
// sample ring store, one write port and one registered read port
// depends on swpm_pkg
`timescale 1ns / 1ps

module swpm_ram (
    input  logic             i_clk,
    input  logic             i_we,
    input  swpm_pkg::t_addr   i_waddr,
    input  swpm_pkg::t_sample i_wdata,
    input  logic             i_re,
    input  swpm_pkg::t_addr   i_raddr,
    output swpm_pkg::t_sample o_rdata
);
    import swpm_pkg::*;

    t_sample r_mem [WINDOW];
    t_sample r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/swpm_scan.sv
// compare unit: running max and min, midpoint of the two
// depends on swpm_pkg
`timescale 1ns / 1ps

module swpm_scan (
    input  logic                i_clk,
    input  swpm_pkg::t_scan_ctl i_ctl,
    input  swpm_pkg::t_sample   i_data,
    output swpm_pkg::t_sample   o_midpoint
);
    import swpm_pkg::*;

    t_sample                r_hi;
    t_sample                r_lo;
    t_sample                n_hi;
    t_sample                n_lo;
    logic [SAMPLE_W:0]      sum;

    always_comb begin
        n_hi = r_hi;
        n_lo = r_lo;
        if (i_ctl.load) begin
            n_hi = i_ctl.sample;
            n_lo = i_ctl.sample;
        end else if (i_ctl.cmp) begin
            if (i_data > r_hi) begin
                n_hi = i_data;
            end
            if (i_data < r_lo) begin
                n_lo = i_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi <= n_hi;
        r_lo <= n_lo;
    end

    assign sum        = {1'b0, r_hi} + {1'b0, r_lo};
    assign o_midpoint = sum[SAMPLE_W:1];

endmodule

// File: rtl/core/sliding_window_peak_midpoint_top.sv
// top level: sequencer, ring pointers, output register
// depends on swpm_pkg, swpm_ram, swpm_scan
//
// channel  dir  fields (tdata, low bit up)
// s_axis   in   sample [11:0], zero pad to 16
// m_axis   out  midpoint [11:0], zero pad to 16
//
// a request steps through scan, drain and done; fill = samples held (at most WINDOW);
// scan makes one store read and one compare per held sample
// input ready only while the sequencer idles; a waiting result leaves input open,
// but the next midpoint holds in the done state until the output register frees
// reset synchronous, active low; store contents need no reset
`timescale 1ns / 1ps

module sliding_window_peak_midpoint_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [swpm_pkg::TDATA_W-1:0] i_s_tdata,  // sample
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [swpm_pkg::TDATA_W-1:0] o_m_tdata   // midpoint
);
    import swpm_pkg::*;

    t_state    r_state, n_state;
    t_addr     r_wr_ptr, n_wr_ptr;
    t_fill     r_fill, n_fill;
    t_addr     r_addr, n_addr;
    logic      r_cmp, n_cmp;
    logic      r_out_vld, n_out_vld;
    t_sample   r_out_data, n_out_data;

    logic      s_acc;
    logic      ram_re;
    t_fill     last_fill;
    t_scan_ctl scan_ctl;
    t_sample   rdata;
    t_sample   midpoint;

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign last_fill  = r_fill - t_fill'(1);

    assign scan_ctl.load   = s_acc;
    assign scan_ctl.cmp    = r_cmp;
    assign scan_ctl.sample = i_s_tdata[SAMPLE_W-1:0];

    swpm_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (s_acc),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_s_tdata[SAMPLE_W-1:0]),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    swpm_scan u_scan (
        .i_clk      (i_clk),
        .i_ctl      (scan_ctl),
        .i_data     (rdata),
        .o_midpoint (midpoint)
    );

    always_comb begin
        n_state    = r_state;
        n_wr_ptr   = r_wr_ptr;
        n_fill     = r_fill;
        n_addr     = r_addr;
        n_cmp      = 1'b0;
        n_out_vld  = r_out_vld && !i_m_tready;
        n_out_data = r_out_data;
        ram_re     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_wr_ptr = (r_wr_ptr == t_addr'(WINDOW - 1)) ? '0
                                                                  : r_wr_ptr + t_addr'(1);
                    n_fill   = (r_fill == t_fill'(WINDOW)) ? r_fill : r_fill + t_fill'(1);
                    n_addr   = '0;
                    n_state  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                ram_re = 1'b1;
                n_cmp  = 1'b1;
                if (r_addr == last_fill[ADDR_W-1:0]) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_addr = r_addr + t_addr'(1);
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_vld || i_m_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_data = midpoint;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_wr_ptr  <= '0;
            r_fill    <= '0;
            r_addr    <= '0;
            r_cmp     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wr_ptr  <= n_wr_ptr;
            r_fill    <= n_fill;
            r_addr    <= n_addr;
            r_cmp     <= n_cmp;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = TDATA_W'(r_out_data);

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= t_fill'(WINDOW))
        else $error("fill count above window");

    a_acc_to_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_state == ST_SCAN) && (r_fill != '0))
        else $error("accepted request did not start scan");

    a_cmp_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp |-> $past(r_state) == ST_SCAN)
        else $error("compare without preceding read");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (t_fill'(r_addr) < r_fill))
        else $error("scan address beyond held samples");
`endif

endmodule

// File: tb/sliding_window_peak_midpoint_top_tb.sv
// testbench for sliding_window_peak_midpoint_top: ring store min/max mid-range over a stream
// depends on swpm_pkg and the top level; predicts each midpoint and checks every result
`timescale 1ns / 1ps

module sliding_window_peak_midpoint_top_tb;

    import swpm_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_s_tvalid;
    logic               o_s_tready;
    logic [TDATA_W-1:0] i_s_tdata;  // sample [11:0], zero pad
    logic               o_m_tvalid;
    logic               i_m_tready;
    logic [TDATA_W-1:0] o_m_tdata;  // midpoint [11:0], zero pad

    t_sample ring_store [WINDOW];
    int      ring_oldest;
    int      ring_fill;
    t_sample expected_midpoints [$];
    int      mismatch_count;
    bit      tx_burst;
    bit      rx_burst;

    sliding_window_peak_midpoint_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic t_sample store_and_midrange(t_sample s);
        t_sample            hi;
        t_sample            lo;
        t_sample            v;
        logic [SAMPLE_W:0]  sum;
        int                 k;
        if (ring_fill < WINDOW) begin
            ring_store[(ring_oldest + ring_fill) % WINDOW] = s;
            ring_fill++;
        end else begin
            ring_store[ring_oldest] = s;
            ring_oldest = (ring_oldest + 1) % WINDOW;
        end
        hi = s;
        lo = s;
        for (k = 0; k < ring_fill; k++) begin
            v = ring_store[(ring_oldest + k) % WINDOW];
            if (v > hi) hi = v;
            if (v < lo) lo = v;
        end
        sum = {1'b0, hi} + {1'b0, lo};
        return sum[SAMPLE_W:1];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_burst || r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_sample(input t_sample s);
        int gap;
        @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tdata  = TDATA_W'(s);
        do @(posedge i_clk); while (!o_s_tready);
        expected_midpoints.push_back(store_and_midrange(s));
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_all_results();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (expected_midpoints.size() != 0) @(posedge i_clk);
    endtask

    // results, compared with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_midpoints.size() == 0) begin
                $error("unexpected result: midpoint %0d", o_m_tdata[SAMPLE_W-1:0]);
                mismatch_count++;
            end else begin
                if (o_m_tdata[SAMPLE_W-1:0] !== expected_midpoints[0]) begin
                    $error("midpoint mismatch: expected %0d, actual %0d",
                           expected_midpoints[0], o_m_tdata[SAMPLE_W-1:0]);
                    mismatch_count++;
                end
                void'(expected_midpoints.pop_front());
            end
        end
    end

    // receiver back-pressure
    initial begin
        int len;
        int stall;
        i_m_tready = 1'b0;
        forever begin
            if ($urandom_range(0, 9) < 3) len = $urandom_range(20, 120);
            else len = $urandom_range(1, 4);
            @(negedge i_clk);
            i_m_tready = 1'b1;
            repeat (len - 1) @(negedge i_clk);
            if (!rx_burst) begin
                if ($urandom_range(0, 9) < 8) stall = $urandom_range(1, 3);
                else stall = $urandom_range(15, 45);
                @(negedge i_clk);
                i_m_tready = 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
        end
    end

    // window still filling: field extremes and bit patterns
    task automatic test_fill_extremes();
        t_sample pattern [16];
        int      k;
        pattern = '{12'd0, 12'd4095, 12'd4095, 12'd0, 12'd2048, 12'd2047, 12'd1, 12'd4094,
                    12'hAAA, 12'h555, 12'h800, 12'h7FF, 12'hFFF, 12'h000, 12'h001, 12'hFFE};
        for (k = 0; k < 16; k++) send_sample(pattern[k]);
        wait_all_results();
    endtask

    // lone peak or trough, then a band of WINDOW-1 to WINDOW+5 samples, so it can age out
    task automatic test_aging_peaks();
        t_sample level;
        int      seg;
        int      k;
        int      run;
        for (seg = 0; seg < 8; seg++) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            level = t_sample'($urandom_range(1000, 3000));
            if (seg % 2 == 0) send_sample(12'd4095);
            else send_sample(12'd0);
            run = WINDOW - 1 + $urandom_range(0, 6);
            for (k = 0; k < run; k++)
                send_sample(level + t_sample'($urandom_range(0, 63)));
        end
        tx_burst = 1'b0;
    endtask

    // after each batch the sender waits for every result; only the second batch bursts
    task automatic test_drain_pause();
        int rep;
        int k;
        for (rep = 0; rep < 3; rep++) begin
            for (k = 0; k < 20; k++) send_sample(t_sample'($urandom()));
            wait_all_results();
            tx_burst = (rep != 1);
            rx_burst = (rep == 2);
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    task automatic test_random_samples();
        int      sent;
        int      kind;
        int      len;
        int      k;
        int      step;
        t_sample v;
        sent = 0;
        while (sent < 350) begin
            kind     = $urandom_range(0, 3);
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 5) == 0);
            v        = t_sample'($urandom());
            step     = $urandom_range(1, 200);
            case (kind)
                0: len = $urandom_range(10, 60);
                1: len = $urandom_range(1, 5);
                2: len = $urandom_range(20, 50);
                default: len = $urandom_range(5, 40);
            endcase
            for (k = 0; k < len; k++) begin
                case (kind)
                    0: v = t_sample'($urandom());
                    1: v = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
                    2: v = (step % 2) ? v + t_sample'(step) : v - t_sample'(step);
                    default: ;
                endcase
                send_sample(v);
            end
            sent += len;
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        ring_oldest    = 0;
        ring_fill      = 0;
        mismatch_count = 0;
        tx_burst       = 1'b0;
        rx_burst       = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_fill_extremes();
        test_aging_peaks();
        test_drain_pause();
        test_random_samples();
        wait_all_results();
        repeat (WINDOW + 8) @(posedge i_clk);
        if (mismatch_count == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule
